/* design/fbb_pkg.sv */
// Shared constants, payload types and control structs of the forward box blur.
package fbb_pkg;

  localparam int MAX_LENGTH = 32;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SLOT_W     = $clog2(MAX_LENGTH);
  localparam int FILL_W     = $clog2(MAX_LENGTH + 1);
  localparam int SUM_W      = $clog2((2 ** CH_W - 1) * MAX_LENGTH + 1);
  localparam int DIV_STEPS  = (SUM_W + 1) / 2;
  localparam int DVD_W      = 2 * DIV_STEPS;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int LEN_W      = 6;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [LEN_W-1:0]    LEN_RESET       = LEN_W'(4);
  localparam logic [ADDR_W-3:0]   REG_BLUR_LENGTH = '0;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic            last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            last_out;
  } pix_out_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic step;
    logic emit;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic need_emit;
    logic last_line;
    logic last_step;
    logic out_free;
  } stat_t;

endpackage

/* design/fbb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fbb_regs.sv */
// Configuration register file with APB-style access and blur length clamping.
module fbb_regs import fbb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  eff_len_o
);

  logic [LEN_W-1:0] blur_q, blur_d;
  logic             sel_blur;

  assign sel_blur = (paddr[ADDR_W-1:2] == REG_BLUR_LENGTH) && (paddr[1:0] == 2'b00);
  assign pready   = 1'b1;

  always_comb begin
    blur_d = blur_q;
    if (psel && penable && pwrite && pready && sel_blur) begin
      blur_d = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blur_q <= LEN_RESET;
    end else begin
      blur_q <= blur_d;
    end
  end

  assign prdata = sel_blur ? DATA_W'(blur_q) : '0;

  always_comb begin
    eff_len_o = blur_q;
    if (blur_q == '0) begin
      eff_len_o = LEN_W'(1);
    end else if ((LEN_W+1)'(blur_q) > (LEN_W+1)'(MAX_LENGTH)) begin
      eff_len_o = LEN_W'(MAX_LENGTH);
    end
  end

endmodule

/* design/fbb_ctrl.sv */
// Controller state machine: sequences pixel intake, division and result emission.
module fbb_ctrl import fbb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.need_emit) begin
          cmd_o.start = 1'b1;
          state_d     = S_DIV;
        end else begin
          cmd_o.flush = stat_i.last_line;
          state_d     = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (stat_i.last_step) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/fbb_dp.sv */
// Datapath: pixel ring store, running channel sums, radix-4 dividers and output register.
module fbb_dp import fbb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  pix_in_t          in_data_i,
  input  logic [LEN_W-1:0] eff_len_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pix_out_t         out_data_o
);

  logic [SUM_W-1:0]  sum_q [3];
  logic [FILL_W-1:0] fill_q;
  logic [SLOT_W-1:0] oldest_q;
  logic              last_q;
  logic              out_valid_q;
  logic [STEP_W-1:0] cnt_q;

  logic [DVD_W-1:0]  dvd_q [3];
  logic [DVD_W-1:0]  dvd_d [3];
  logic [FILL_W-1:0] rem_q [3];
  logic [FILL_W-1:0] rem_d [3];
  logic [DVD_W-1:0]  quo_q [3];
  logic [DVD_W-1:0]  quo_d [3];
  pix_out_t          out_q;

  logic [FILL_W:0]   slot_sum;
  logic [SLOT_W-1:0] wslot;
  logic [PIX_W-1:0]  wpix;
  logic [PIX_W-1:0]  rpix;
  logic [CH_W-1:0]   in_ch  [3];
  logic [CH_W-1:0]   old_ch [3];

  assign in_ch[0]  = in_data_i.red_in;
  assign in_ch[1]  = in_data_i.green_in;
  assign in_ch[2]  = in_data_i.blue_in;
  assign wpix      = {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
  assign old_ch[0] = rpix[3*CH_W-1:2*CH_W];
  assign old_ch[1] = rpix[2*CH_W-1:CH_W];
  assign old_ch[2] = rpix[CH_W-1:0];

  always_comb begin
    slot_sum = (FILL_W+1)'(oldest_q) + (FILL_W+1)'(fill_q);
    if (slot_sum >= (FILL_W+1)'(MAX_LENGTH)) begin
      slot_sum = slot_sum - (FILL_W+1)'(MAX_LENGTH);
    end
    wslot = slot_sum[SLOT_W-1:0];
  end

  fbb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LENGTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (wslot),
    .wdata_i (wpix),
    .re_i    (cmd_i.start),
    .raddr_i (oldest_q),
    .rdata_o (rpix)
  );

  always_comb begin
    logic [FILL_W:0]   t;
    logic [FILL_W-1:0] r;
    logic [DVD_W-1:0]  d;
    logic [DVD_W-1:0]  q;
    for (int ch = 0; ch < 3; ch++) begin
      r = rem_q[ch];
      d = dvd_q[ch];
      q = quo_q[ch];
      for (int k = 0; k < 2; k++) begin
        t = {r, d[DVD_W-1]};
        d = {d[DVD_W-2:0], 1'b0};
        if (t >= {1'b0, fill_q}) begin
          t = t - {1'b0, fill_q};
          q = {q[DVD_W-2:0], 1'b1};
        end else begin
          q = {q[DVD_W-2:0], 1'b0};
        end
        r = t[FILL_W-1:0];
      end
      rem_d[ch] = r;
      dvd_d[ch] = d;
      quo_d[ch] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd_i.start) begin
        dvd_q[ch] <= DVD_W'(sum_q[ch]);
        rem_q[ch] <= '0;
        quo_q[ch] <= '0;
      end else if (cmd_i.step) begin
        dvd_q[ch] <= dvd_d[ch];
        rem_q[ch] <= rem_d[ch];
        quo_q[ch] <= quo_d[ch];
      end
    end
    if (cmd_i.emit) begin
      out_q.red_out   <= quo_q[0][CH_W-1:0];
      out_q.green_out <= quo_q[1][CH_W-1:0];
      out_q.blue_out  <= quo_q[2][CH_W-1:0];
      out_q.last_out  <= last_q && (fill_q == FILL_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch] <= '0;
      end
      fill_q      <= '0;
      oldest_q    <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.accept) begin
        for (int ch = 0; ch < 3; ch++) begin
          sum_q[ch] <= sum_q[ch] + SUM_W'(in_ch[ch]);
        end
        fill_q <= fill_q + FILL_W'(1);
        last_q <= in_data_i.last_pixel;
      end else if (cmd_i.emit) begin
        for (int ch = 0; ch < 3; ch++) begin
          sum_q[ch] <= sum_q[ch] - SUM_W'(old_ch[ch]);
        end
        fill_q <= fill_q - FILL_W'(1);
        if (oldest_q == SLOT_W'(MAX_LENGTH - 1)) begin
          oldest_q <= '0;
        end else begin
          oldest_q <= oldest_q + SLOT_W'(1);
        end
      end else if (cmd_i.flush) begin
        for (int ch = 0; ch < 3; ch++) begin
          sum_q[ch] <= '0;
        end
        oldest_q <= '0;
      end
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + STEP_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.need_emit = (fill_q != '0) &&
                            (last_q || ((LEN_W+1)'(fill_q) >= (LEN_W+1)'(eff_len_i)));
  assign stat_o.last_line = last_q;
  assign stat_o.last_step = (cnt_q == STEP_W'(DIV_STEPS - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/forward_box_blur_rgb.sv */
// Top level of the forward box blur over a stream of RGB pixels.
// Input channel: one pixel per transfer on in_valid_i/in_ready_o, with a
// last_pixel flag closing the image line. Output channel: averaged pixels on
// out_valid_o/out_ready_i; last_out marks the final result of a line.
// Each result averages the next blur_length pixels; near the end of the line
// the window shrinks to the pixels still held. blur_length sits at byte
// address 0 of the APB port; the user must write it only while the block is
// idle, which the block does not enforce. A pixel that completes a window is
// followed by one result after a window check, a 2-bit-per-cycle divider run
// per channel and an emit; each further result of a flush repeats these steps.
// A pixel that yields no result is absorbed by the window check alone.
// The block takes one pixel at a time; the next pixel is accepted after
// all results of the previous one have been loaded into the output register.
// A stalled receiver holds the result in the output register and pauses the
// block once the next result is ready. Reset empties the window, clears the
// sums and sets blur_length to 4; the pixel store needs no clearing.
module forward_box_blur_rgb import fbb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pix_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pix_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cmd_t             cmd;
  stat_t            stat;
  logic [LEN_W-1:0] eff_len;

  fbb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_len_o (eff_len)
  );

  fbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fbb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .eff_len_i   (eff_len),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* design/fbb_checker.sv */
// Port-level checker of the forward box blur, bound to the top level.
module fbb_checker import fbb_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input pix_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input pix_out_t out_data_o,
  input logic     pready
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before its transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_pixel |=> !in_ready_o)
    else $error("last pixel did not start a flush");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind forward_box_blur_rgb fbb_checker u_fbb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);
